/* rtl/core/prrt_pkg.sv */
// prrt_pkg: shared types and constants of the pending request retry table
// holds result codes, command codes, reset values and the slot entry layout
// no dependencies
package prrt_pkg;

  // default number of table slots
  localparam int SLOTS_DEF = 16;

  // largest accepted name count of a new request
  localparam logic [3:0] MAX_NAMES = 4'd8;

  // reset values
  localparam logic [3:0]  MAX_SENDS_RST = 4'd4;
  localparam logic [15:0] ID_RST        = 16'd1;

  // message type that marks a response
  localparam logic [7:0] RSP_TYPE_RESPONSE = 8'd1;

  // command codes
  localparam logic [1:0] CMD_NEW  = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_RESP = 2'd2;

  // result codes
  typedef enum logic [2:0] {
    EV_ACCEPTED = 3'd0,
    EV_FULL     = 3'd1,
    EV_BADCOUNT = 3'd2,
    EV_RESEND   = 3'd3,
    EV_TIMEOUT  = 3'd4,
    EV_ANSWERED = 3'd5,
    EV_DROPPED  = 3'd6,
    EV_IDLE     = 3'd7
  } event_t;

  // one slot entry as kept in the slot memory
  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  names;
    logic [3:0]  count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/core/prrt_ram.sv */
// prrt_ram: generic single write port, single read port synchronous ram
// read data is registered
// no dependencies
module prrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/pending_request_retry_table.sv */
// pending_request_retry_table: top level of the pending request retry table
// depends on prrt_pkg and prrt_ram (slot memory of id, name count, send count)
//
//   channel   handshake                    payload
//   -------   ---------------------------  ----------------------------------------
//   command   start, busy (accept: start   cmd, query_count, response_id,
//             high while busy low)         response_type
//   result    result_strobe (one cycle,    event_res, slot, request_id,
//             no back pressure)            names_count, last
//   config    max_sends_we                 max_sends_wdata
//
// a bad count, a non-response message or an idle tick gets its result straight from
// idle, and an unused command is ignored; a new request scans the slot flags one per
// cycle, a tick or a response scans the slots one per cycle through the registered
// read port of the slot memory (a new request or a matched response ends at the
// slot found); results are registered, at most one per cycle
// rst clears the busy flags, the id counter (to 1) and max_sends (to 4); the
// slot memory needs no clearing, entries are read only while their slot is busy
// the receiver cannot stall, so results are never held
module pending_request_retry_table
  import prrt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic        clk,
  input  logic        rst,
  // command
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [3:0]  query_count,
  input  logic [15:0] response_id,
  input  logic [7:0]  response_type,
  // result
  output logic        result_strobe,
  output logic [2:0]  event_res,
  output logic [3:0]  slot,
  output logic [15:0] request_id,
  output logic [3:0]  names_count,
  output logic        last,
  // configuration
  input  logic        max_sends_we,
  input  logic [3:0]  max_sends_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_TICK,
    ST_RESP
  } state_t;

  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  state_t            state;
  logic [SLOTS-1:0]  slot_busy;
  logic [15:0]       next_id;
  logic [3:0]        max_sends;

  // latched command operands
  logic [3:0]        op_names;
  logic [15:0]       op_id;

  // scan position and read stage
  logic [CW-1:0]     idx;
  logic [IW-1:0]     idx_s;
  logic              pv;
  logic [IW-1:0]     p_idx;

  // slot memory ports
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;
  entry_t            rd;

  logic [SLOTS-1:0]  above;
  logic              more_busy;
  logic              cnt_ok;
  logic              rsp_hit;

  // registered result fields
  event_t            ev_q;

  assign idx_s = idx[IW-1:0];
  assign rd    = entry_t'(mem_rdata);
  assign busy  = (state != ST_IDLE);
  assign event_res = ev_q;

  function automatic logic [3:0] slot_of(input logic [IW-1:0] i);
    logic [IW+3:0] w;
    w = {4'b0000, i};
    return w[3:0];
  endfunction

  // busy slots above the one in the read stage
  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      above[k] = (IW'(k) > p_idx);
    end
  end
  assign more_busy = |(slot_busy & above);

  assign cnt_ok  = (query_count != 4'd0) && (query_count <= MAX_NAMES);
  assign rsp_hit = pv && (rd.id == op_id);

  // slot memory write: allocation in the scan stage, resend in the read stage
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_s;
    mem_wdata = '{id: next_id, names: op_names, count: 4'd1};
    case (state)
      ST_ALLOC: begin
        mem_we = (idx != SLOTS_C) && !slot_busy[idx_s];
      end
      ST_TICK: begin
        mem_we    = pv && (rd.count < max_sends);
        mem_waddr = p_idx;
        mem_wdata = '{id: rd.id, names: rd.names, count: rd.count + 4'd1};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  prrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_s),
    .rdata (mem_rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_sends <= MAX_SENDS_RST;
    end else if (max_sends_we) begin
      max_sends <= max_sends_wdata;
    end
  end

  // control state machine, slot flags and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slot_busy     <= '0;
      next_id       <= ID_RST;
      pv            <= 1'b0;
      idx           <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          idx      <= '0;
          pv       <= 1'b0;
          op_names <= query_count;
          op_id    <= response_id;
          if (start) begin
            case (cmd)
              CMD_NEW: begin
                if (cnt_ok) begin
                  state <= ST_ALLOC;
                end else begin
                  result_strobe <= 1'b1;
                  ev_q          <= EV_BADCOUNT;
                  slot          <= 4'd0;
                  request_id    <= 16'd0;
                  names_count   <= 4'd0;
                  last          <= 1'b1;
                end
              end
              CMD_TICK: begin
                if (|slot_busy) begin
                  state <= ST_TICK;
                end else begin
                  result_strobe <= 1'b1;
                  ev_q          <= EV_IDLE;
                  slot          <= 4'd0;
                  request_id    <= 16'd0;
                  names_count   <= 4'd0;
                  last          <= 1'b1;
                end
              end
              CMD_RESP: begin
                if (response_type == RSP_TYPE_RESPONSE) begin
                  state <= ST_RESP;
                end else begin
                  result_strobe <= 1'b1;
                  ev_q          <= EV_DROPPED;
                  slot          <= 4'd0;
                  request_id    <= response_id;
                  names_count   <= 4'd0;
                  last          <= 1'b1;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end

        // first free slot, one slot per cycle
        ST_ALLOC: begin
          if (idx == SLOTS_C) begin
            result_strobe <= 1'b1;
            ev_q          <= EV_FULL;
            slot          <= 4'd0;
            request_id    <= 16'd0;
            names_count   <= 4'd0;
            last          <= 1'b1;
            state         <= ST_IDLE;
          end else if (!slot_busy[idx_s]) begin
            slot_busy[idx_s] <= 1'b1;
            result_strobe    <= 1'b1;
            ev_q             <= EV_ACCEPTED;
            slot             <= slot_of(idx_s);
            request_id       <= next_id;
            names_count      <= op_names;
            last             <= 1'b1;
            next_id          <= next_id + 16'd1;
            state            <= ST_IDLE;
          end else begin
            idx <= idx + CW'(1);
          end
        end

        // every busy slot: read in the scan stage, update in the read stage
        ST_TICK: begin
          if (pv) begin
            result_strobe <= 1'b1;
            slot          <= slot_of(p_idx);
            request_id    <= rd.id;
            names_count   <= rd.names;
            last          <= !more_busy;
            if (rd.count >= max_sends) begin
              ev_q             <= EV_TIMEOUT;
              slot_busy[p_idx] <= 1'b0;
            end else begin
              ev_q <= EV_RESEND;
            end
          end
          if (idx != SLOTS_C) begin
            pv    <= slot_busy[idx_s];
            p_idx <= idx_s;
            idx   <= idx + CW'(1);
          end else begin
            pv    <= 1'b0;
            state <= ST_IDLE;
          end
        end

        // lowest busy slot holding the response id
        ST_RESP: begin
          if (rsp_hit) begin
            result_strobe    <= 1'b1;
            ev_q             <= EV_ANSWERED;
            slot             <= slot_of(p_idx);
            request_id       <= rd.id;
            names_count      <= rd.names;
            last             <= 1'b1;
            slot_busy[p_idx] <= 1'b0;
            pv               <= 1'b0;
            state            <= ST_IDLE;
          end else if (idx == SLOTS_C) begin
            result_strobe <= 1'b1;
            ev_q          <= EV_DROPPED;
            slot          <= 4'd0;
            request_id    <= op_id;
            names_count   <= 4'd0;
            last          <= 1'b1;
            pv            <= 1'b0;
            state         <= ST_IDLE;
          end else begin
            pv    <= slot_busy[idx_s];
            p_idx <= idx_s;
            idx   <= idx + CW'(1);
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a result only follows an accepted command or a scan in progress
  a_strobe_source: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy || start))
    else $error("result without a transaction in progress");

  // the read stage is empty whenever the block is idle
  a_idle_stage: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pv)
    else $error("read stage left valid in idle");

  // an allocated slot is marked busy on the next cycle
  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALLOC && idx != SLOTS_C && !slot_busy[idx_s])
      |=> slot_busy[$past(idx_s)])
    else $error("allocated slot not marked busy");

  // an accepted request carries the id just handed out
  a_accept_id: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && ev_q == EV_ACCEPTED) |-> (request_id == next_id - 16'd1))
    else $error("accepted id does not match id counter");

endmodule
